// ===== sv/bshl_pkg.sv =====
// ----------------------------------------------------------------------------
// bshl_pkg - shared types and constants of the bounded sorted hit list
// Entry and control types, command codes and sizes used by the cell chain.
// ----------------------------------------------------------------------------
package bshl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 32;
    localparam int RANK_W      = 4;
    localparam int CMD_W       = 2;
    localparam int CAP_W       = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             uv;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // per-cell control from the list controller
    typedef struct packed {
        logic ins;      // insert in progress
        logic rot;      // rotate one place toward the head
        logic is_pos;   // cell where the new item is first written
        logic is_tail;  // last occupied cell, refilled from the head
    } cell_ctrl_t;

endpackage

// ===== sv/bshl_cell.sv =====
// ----------------------------------------------------------------------------
// bshl_cell - one entry of the sorted hit list
// Holds one hit; on insert it keeps, shifts back or takes the new item,
// on read-out it rotates one place toward the head.
// ----------------------------------------------------------------------------
module bshl_cell (
    input  logic                clk,
    input  bshl_pkg::cell_ctrl_t ctrl,
    input  bshl_pkg::entry_t    new_entry,
    input  bshl_pkg::entry_t    prev_entry,
    input  bshl_pkg::entry_t    next_entry,
    input  bshl_pkg::entry_t    head_entry,
    input  logic                run_above,
    input  logic                run_below,
    input  logic                shift_below,
    output bshl_pkg::entry_t    entry,
    output logic                run,
    output logic                shift
);
    import bshl_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   ranks_after;
    logic   take_new;

    // the held entry would sit after the new item
    assign ranks_after = (entry_reg.key > new_entry.key) ||
                         ((entry_reg.key == new_entry.key) && !entry_reg.uv);

    // run: every cell from here up to the insert position lets the item pass
    assign run      = ctrl.is_pos || (ranks_after && run_above);
    assign shift    = run && !ctrl.is_pos;
    assign take_new = run && !run_below;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (shift_below)
            begin
                entry_next = prev_entry;
            end
            else if (take_new)
            begin
                entry_next = new_entry;
            end
        end
        else if (ctrl.rot)
        begin
            entry_next = ctrl.is_tail ? head_entry : next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== sv/bounded_sorted_hit_list_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_sorted_hit_list_unit - nearest-hit list kept sorted by distance
// Chain of entry cells with a small controller for count and read-out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes commands: insert a hit, read
//   out the list, or clear it. Output channel (out_valid / out_stall) gives
//   one item per held entry on a read, nearest first, with rank and last.
//   Config channel (cfg_valid / cfg_ready) writes the capacity; write it
//   only while no read-out is running. 0 is taken as 1, above 16 as 16.
//   One command per cycle is taken while in_stall is low; insert and clear
//   never raise it. An insert compares against every cell at once and
//   shifts the chain in the same cycle. On a read the chain rotates one
//   place per item through the head cell, and in_stall stays high until
//   the last item has been loaded into the output register. A taken read
//   first enters the read state; the head item is then registered for output.
//   When the receiver stalls, the output register holds its item and the
//   rotation waits. Reset empties the list and sets capacity to 16.
// ----------------------------------------------------------------------------
module bounded_sorted_hit_list_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bshl_pkg::CMD_W-1:0]    cmd,
    input  logic [bshl_pkg::KEY_W-1:0]    key,
    input  logic                          uv_given,
    input  logic [bshl_pkg::TAG_W-1:0]    tag,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bshl_pkg::KEY_W-1:0]    out_key,
    output logic                          out_uv_given,
    output logic [bshl_pkg::TAG_W-1:0]    out_tag,
    output logic [bshl_pkg::RANK_W-1:0]   rank,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bshl_pkg::CAP_W-1:0]    cfg_data
);
    import bshl_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     cap_reg, cap_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 out_valid_reg, out_valid_next;
    entry_t               out_entry_reg;
    logic [RANK_W-1:0]    rank_reg;
    logic                 last_reg;

    entry_t               cells   [MAX_ENTRIES];
    logic                 run_w   [MAX_ENTRIES];
    logic                 shift_w [MAX_ENTRIES];
    cell_ctrl_t           ctrl_w  [MAX_ENTRIES];

    entry_t               new_entry;
    entry_t               tail_entry;
    logic                 accept;
    logic                 step;
    logic                 do_ins;
    logic                 do_rot;
    logic                 full;
    logic                 is_last;
    logic [IDX_W-1:0]     ins_pos;
    logic [IDX_W-1:0]     cap_last;
    logic [IDX_W-1:0]     fill_last;
    logic [CNT_W-1:0]     cfg_cap;

    assign new_entry = '{key: key, uv: uv_given, tag: tag};
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg == ST_READ);
    assign cfg_ready = 1'b1;

    assign full       = (fill_reg >= cap_reg);
    assign cap_last   = IDX_W'(cap_reg - CNT_W'(1));
    assign fill_last  = IDX_W'(fill_reg - CNT_W'(1));
    assign tail_entry = cells[cap_last];
    assign ins_pos    = full ? cap_last : IDX_W'(fill_reg);

    // drop an insert into a full list unless it beats the last entry
    assign do_ins = accept && (cmd == CMD_INSERT) && (!full || (key < tail_entry.key));

    assign step    = (state_reg == ST_READ) && (!out_valid_reg || !out_stall);
    assign do_rot  = step;
    assign is_last = (rd_idx_reg == fill_last);

    always_comb
    begin
        if (cfg_data == CAP_W'(0))
        begin
            cfg_cap = CNT_W'(1);
        end
        else if (32'(cfg_data) > MAX_ENTRIES)
        begin
            cfg_cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cfg_cap = CNT_W'(cfg_data);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_READ) && (fill_reg != CNT_W'(0)))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (step && is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // count, capacity, read index and output register control
    always_comb
    begin
        fill_next      = fill_reg;
        cap_next       = cap_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_idx_next = '0;
                if (accept)
                begin
                    unique case (cmd)
                        CMD_INSERT:
                        begin
                            if (!full)
                            begin
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (step)
                begin
                    out_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                rd_idx_next = '0;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_cap;
            if (fill_reg > cfg_cap)
            begin
                fill_next = cfg_cap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cap_reg       <= CNT_W'(MAX_ENTRIES);
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cap_reg       <= cap_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload: always taken from the head cell
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_entry_reg <= cells[0];
            rank_reg      <= RANK_W'(rd_idx_reg);
            last_reg      <= is_last;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            assign ctrl_w[gi].ins     = do_ins;
            assign ctrl_w[gi].rot     = do_rot && (CNT_W'(gi) < fill_reg);
            assign ctrl_w[gi].is_pos  = (ins_pos == IDX_W'(gi));
            assign ctrl_w[gi].is_tail = (fill_last == IDX_W'(gi));

            bshl_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl_w[gi]),
                .new_entry   (new_entry),
                .prev_entry  ((gi == 0) ? new_entry : cells[(gi == 0) ? 0 : gi - 1]),
                .next_entry  ((gi == MAX_ENTRIES - 1) ? cells[0] :
                              cells[(gi == MAX_ENTRIES - 1) ? 0 : gi + 1]),
                .head_entry  (cells[0]),
                .run_above   ((gi == MAX_ENTRIES - 1) ? 1'b0 :
                              run_w[(gi == MAX_ENTRIES - 1) ? 0 : gi + 1]),
                .run_below   ((gi == 0) ? 1'b0 : run_w[(gi == 0) ? 0 : gi - 1]),
                .shift_below ((gi == 0) ? 1'b0 : shift_w[(gi == 0) ? 0 : gi - 1]),
                .entry       (cells[gi]),
                .run         (run_w[gi]),
                .shift       (shift_w[gi])
            );
        end
    endgenerate

    assign out_valid    = out_valid_reg;
    assign out_key      = out_entry_reg.key;
    assign out_uv_given = out_entry_reg.uv;
    assign out_tag      = out_entry_reg.tag;
    assign rank         = rank_reg;
    assign last         = last_reg;

endmodule

// ===== sv/bshl_checker.sv =====
// ----------------------------------------------------------------------------
// bshl_checker - port-level checks of the sorted hit list
// Watches the read-out runs on the top level's ports.
// ----------------------------------------------------------------------------
module bshl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [bshl_pkg::KEY_W-1:0]    out_key,
    input logic [bshl_pkg::TAG_W-1:0]    out_tag,
    input logic [bshl_pkg::RANK_W-1:0]   rank,
    input logic                          last
);
    import bshl_pkg::*;

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_key) && $stable(out_tag)
                                   && $stable(rank) && $stable(last))
        else $error("stalled output item changed");

    // a run begins at the nearest entry
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (rank == RANK_W'(0)))
        else $error("read-out run did not start at rank 0");

    // a run continues without gaps until its last item
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && (rank == $past(rank) + RANK_W'(1)))
        else $error("read-out run broke before its last item");

    // no new command is taken in the middle of a run
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input taken during read-out");

endmodule

bind bounded_sorted_hit_list_unit bshl_checker u_bshl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .rank      (rank),
    .last      (last)
);
